/* rtl/core/i2cee_pkg.sv */
// Shared types, codes and event decoding for the I2C memory emulator.
package i2cee_pkg;

    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    localparam logic [1:0] MODE_BUS  = 2'd0;
    localparam logic [1:0] MODE_HWR  = 2'd1;
    localparam logic [1:0] MODE_HRD  = 2'd2;

    localparam logic [2:0] REG_ADDR_COUNT  = 3'd0;
    localparam logic [2:0] REG_SLAVE_ADDR0 = 3'd1;
    localparam logic [2:0] REG_MEM_SIZE    = 3'd5;
    localparam int         NUM_ADDR_REGS   = 4;

    localparam logic [6:0] SLAVE_ADDR_RST = 7'h50;
    localparam logic [8:0] MASK_ADDR      = 9'h100;
    localparam logic [8:0] MASK_MSB       = 9'h080;
    localparam logic [8:0] MASK_LSB       = 9'h001;

    localparam logic [3:0] EC_FALL_SDA0  = 4'b0010;
    localparam logic [3:0] EC_RISE_SDA0  = 4'b0011;
    localparam logic [3:0] EC_IDLE_LOW   = 4'b0100;
    localparam logic [3:0] EC_FALL_SDA1  = 4'b0110;
    localparam logic [3:0] EC_RISE_SDA1  = 4'b0111;
    localparam logic [3:0] EC_SDA_FALL0  = 4'b1000;
    localparam logic [3:0] EC_START      = 4'b1001;
    localparam logic [3:0] EC_SDA_RISE0  = 4'b1100;
    localparam logic [3:0] EC_STOP       = 4'b1101;

    typedef enum logic [2:0] {
        EV_NONE,
        EV_ERR,
        EV_START,
        EV_STOP,
        EV_RISE0,
        EV_RISE1,
        EV_FALL
    } t_ev;

    function automatic t_ev ev_decode(input logic [3:0] code);
        t_ev ev;
        unique case (code) inside
            EC_RISE_SDA0:                          ev = EV_RISE0;
            EC_RISE_SDA1:                          ev = EV_RISE1;
            EC_FALL_SDA0, EC_FALL_SDA1:            ev = EV_FALL;
            EC_START:                              ev = EV_START;
            EC_STOP:                               ev = EV_STOP;
            EC_IDLE_LOW, EC_SDA_FALL0, EC_SDA_RISE0: ev = EV_NONE;
            default:                               ev = EV_ERR;
        endcase
        return ev;
    endfunction

endpackage

/* rtl/core/i2c_eeprom_slave_emulator.sv */
// I2C slave emulating a byte memory: bus event decoding, host access, APB registers.
// Each input is taken while idle, decoded, and its result registered for output. A
// memory byte read (host read, start of a read byte) adds a read-wait state, and a
// completed sub-address byte adds the 8-step remainder unit. No new input is taken
// until the last result is handed to the output, which can stall on i_out_ready.
// Reset clears control state and sets APB registers to defaults; memory is undefined until written.
module i2c_eeprom_slave_emulator
    import i2cee_pkg::*;
#(
    parameter int MEM_DEPTH  = 256,
    parameter int ADDR_SLOTS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_mode,
    input  logic [3:0]         i_event_code,
    input  logic [7:0]         i_host_addr,
    input  logic [7:0]         i_host_wdata,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_sda_drive_low,
    output logic               o_bus_busy,
    output logic               o_bus_free_pulse,
    output logic               o_write_done_pulse,
    output logic               o_read_done_pulse,
    output logic [7:0]         o_matched_address,
    output logic [7:0]         o_host_read_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AW = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_RDW,
        S_MOD,
        S_OUT
    } t_state;

    typedef enum logic [2:0] {
        PH_WAIT,
        PH_ADDR,
        PH_SUB,
        PH_DATA,
        PH_TX
    } t_phase;

    t_state      r_state, n_state;
    t_phase      r_phase, n_phase;
    logic [1:0]  r_mode;
    logic [3:0]  r_code;
    logic [7:0]  r_haddr;
    logic [7:0]  r_hwdata;
    logic [8:0]  r_mask, n_mask;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_sub, n_sub;
    logic        r_sda, n_sda;
    logic        r_busy, n_busy;
    logic        r_written_mark, n_written_mark;
    logic        r_read_mark, n_read_mark;
    logic [7:0]  r_matched, n_matched;
    logic        r_p_free, n_p_free;
    logic        r_p_write, n_p_write;
    logic        r_p_read, n_p_read;
    logic [7:0]  r_hread, n_hread;
    logic        r_rd_host, n_rd_host;
    logic [7:0]  r_mod_rem, n_mod_rem;
    logic [2:0]  r_mod_cnt, n_mod_cnt;

    logic        r_o_valid;
    logic        r_o_sda;
    logic        r_o_busy;
    logic        r_o_free;
    logic        r_o_write;
    logic        r_o_read;
    logic [7:0]  r_o_matched;
    logic [7:0]  r_o_hread;

    logic [2:0]  r_addr_count;
    logic [6:0]  r_slave_addr [ADDR_SLOTS];
    logic [8:0]  r_mem_size;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [7:0]    mem_wdata;
    logic [AW-1:0] mem_raddr;
    logic [7:0]    mem_rdata;

    logic [8:0]  eff_size;
    logic [3:0]  slot_count;
    logic        cfg_we;
    logic [2:0]  cfg_idx;
    logic        out_free;

    i2cee_ram #(
        .WIDTH (8),
        .DEPTH (MEM_DEPTH)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    function automatic logic [AW-1:0] host_index(input logic [7:0] a);
        logic [16:0] t;
        t = 17'(a);
        for (int k = 7; k >= 0; k--) begin
            if (t >= (17'(MEM_DEPTH) << k)) begin
                t = t - (17'(MEM_DEPTH) << k);
            end
        end
        return t[AW-1:0];
    endfunction

    function automatic logic [7:0] next_sub(input logic [7:0] s, input logic [8:0] lim);
        logic [8:0] inc;
        inc = {1'b0, s} + 9'd1;
        return (inc >= lim) ? 8'd0 : inc[7:0];
    endfunction

    assign eff_size   = (r_mem_size == 9'd0 || r_mem_size > 9'(MEM_DEPTH)) ?
                        9'(MEM_DEPTH) : r_mem_size;
    assign slot_count = ({1'b0, r_addr_count} > 4'(ADDR_SLOTS)) ?
                        4'(ADDR_SLOTS) : {1'b0, r_addr_count};
    assign out_free   = !r_o_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        t_ev         ev;
        logic [7:0]  sh_new;
        logic        hit;
        logic        end_now;
        logic [16:0] dshift;

        n_state        = r_state;
        n_phase        = r_phase;
        n_mask         = r_mask;
        n_shift        = r_shift;
        n_sub          = r_sub;
        n_sda          = r_sda;
        n_busy         = r_busy;
        n_written_mark = r_written_mark;
        n_read_mark    = r_read_mark;
        n_matched      = r_matched;
        n_p_free       = r_p_free;
        n_p_write      = r_p_write;
        n_p_read       = r_p_read;
        n_hread        = r_hread;
        n_rd_host      = r_rd_host;
        n_mod_rem      = r_mod_rem;
        n_mod_cnt      = r_mod_cnt;
        mem_we         = 1'b0;
        mem_waddr      = r_sub[AW-1:0];
        mem_wdata      = r_shift;
        ev             = ev_decode(r_code);
        sh_new         = (ev == EV_RISE1) ? (r_shift | r_mask[7:0]) : r_shift;
        hit            = (slot_count == 4'd0);
        end_now        = 1'b0;
        dshift         = 17'(eff_size) << r_mod_cnt;

        for (int i = 0; i < ADDR_SLOTS; i++) begin
            if (4'(i) < slot_count && sh_new[7:1] == r_slave_addr[i]) begin
                hit = 1'b1;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_p_free  = 1'b0;
                n_p_write = 1'b0;
                n_p_read  = 1'b0;
                n_hread   = 8'd0;
                n_rd_host = 1'b0;
                n_state   = S_OUT;
                unique case (r_mode)
                    MODE_HWR: begin
                        mem_we    = 1'b1;
                        mem_waddr = host_index(r_haddr);
                        mem_wdata = r_hwdata;
                    end
                    MODE_HRD: begin
                        n_rd_host = 1'b1;
                        n_state   = S_RDW;
                    end
                    MODE_BUS: begin
                        unique case (ev)
                            EV_START: begin
                                end_now = 1'b1;
                                n_busy  = 1'b1;
                                n_mask  = MASK_ADDR;
                                n_shift = 8'd0;
                            end
                            EV_STOP: begin
                                end_now  = 1'b1;
                                n_busy   = 1'b0;
                                n_p_free = 1'b1;
                            end
                            EV_ERR: begin
                                end_now = 1'b1;
                            end
                            EV_RISE0, EV_RISE1, EV_FALL: begin
                                if (r_phase == PH_ADDR || r_phase == PH_SUB ||
                                    r_phase == PH_DATA) begin
                                    if (ev != EV_FALL) begin
                                        n_shift = sh_new;
                                        if (r_mask == MASK_LSB) begin
                                            if (r_phase == PH_ADDR) begin
                                                if (hit) begin
                                                    n_matched = sh_new;
                                                end else begin
                                                    end_now = 1'b1;
                                                end
                                            end else if (r_phase == PH_SUB) begin
                                                n_mod_rem = sh_new;
                                                n_mod_cnt = 3'd7;
                                                n_state   = S_MOD;
                                            end else begin
                                                mem_we         = 1'b1;
                                                mem_wdata      = sh_new;
                                                n_sub          = next_sub(r_sub, eff_size);
                                                n_written_mark = 1'b1;
                                            end
                                        end
                                    end else if (r_mask == 9'd0) begin
                                        n_mask = MASK_MSB;
                                        if (r_phase == PH_ADDR && r_shift[0]) begin
                                            n_phase = PH_TX;
                                            n_state = S_RDW;
                                        end else begin
                                            n_sda   = 1'b0;
                                            n_shift = 8'd0;
                                            if (r_phase != PH_DATA) begin
                                                n_phase = (r_phase == PH_ADDR) ?
                                                          PH_SUB : PH_DATA;
                                            end
                                        end
                                    end else begin
                                        if (r_mask == MASK_LSB) begin
                                            n_sda = 1'b1;
                                        end
                                        n_mask = r_mask >> 1;
                                    end
                                end else if (r_phase == PH_TX) begin
                                    if (ev == EV_RISE1) begin
                                        if ((r_shift & r_mask[7:0]) == 8'd0 ||
                                            r_mask[8]) begin
                                            end_now = 1'b1;
                                        end
                                    end else if (ev == EV_FALL) begin
                                        if (r_mask == MASK_LSB) begin
                                            n_sda  = 1'b0;
                                            n_mask = 9'd0;
                                        end else if (r_mask == 9'd0) begin
                                            n_mask      = MASK_MSB;
                                            n_sub       = next_sub(r_sub, eff_size);
                                            n_read_mark = 1'b1;
                                            n_state     = S_RDW;
                                        end else begin
                                            n_mask = r_mask >> 1;
                                            n_sda  = ((r_shift & n_mask[7:0]) == 8'd0);
                                        end
                                    end
                                end
                            end
                            default: begin
                            end
                        endcase
                        if (end_now) begin
                            n_sda          = 1'b0;
                            n_p_read       = r_read_mark;
                            n_read_mark    = 1'b0;
                            n_p_write      = r_written_mark;
                            n_written_mark = 1'b0;
                            n_phase        = (ev == EV_START) ? PH_ADDR : PH_WAIT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_RDW: begin
                if (r_rd_host) begin
                    n_hread = mem_rdata;
                end else begin
                    n_shift = mem_rdata;
                    n_sda   = !mem_rdata[7];
                end
                n_state = S_OUT;
            end
            S_MOD: begin
                if (17'(r_mod_rem) >= dshift) begin
                    n_mod_rem = r_mod_rem - dshift[7:0];
                end
                n_mod_cnt = r_mod_cnt - 3'd1;
                if (r_mod_cnt == 3'd0) begin
                    n_sub   = n_mod_rem;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        mem_raddr = (r_mode == MODE_HRD) ? host_index(r_haddr) : n_sub[AW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_phase        <= PH_WAIT;
            r_mask         <= 9'd0;
            r_shift        <= 8'd0;
            r_sub          <= 8'd0;
            r_sda          <= 1'b0;
            r_busy         <= 1'b0;
            r_written_mark <= 1'b0;
            r_read_mark    <= 1'b0;
            r_matched      <= 8'd0;
            r_p_free       <= 1'b0;
            r_p_write      <= 1'b0;
            r_p_read       <= 1'b0;
            r_hread        <= 8'd0;
            r_rd_host      <= 1'b0;
            r_mod_rem      <= 8'd0;
            r_mod_cnt      <= 3'd0;
            r_o_valid      <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_phase        <= n_phase;
            r_mask         <= n_mask;
            r_shift        <= n_shift;
            r_sub          <= n_sub;
            r_sda          <= n_sda;
            r_busy         <= n_busy;
            r_written_mark <= n_written_mark;
            r_read_mark    <= n_read_mark;
            r_matched      <= n_matched;
            r_p_free       <= n_p_free;
            r_p_write      <= n_p_write;
            r_p_read       <= n_p_read;
            r_hread        <= n_hread;
            r_rd_host      <= n_rd_host;
            r_mod_rem      <= n_mod_rem;
            r_mod_cnt      <= n_mod_cnt;
            if (r_state == S_OUT && out_free) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
        if (r_state == S_IDLE && i_in_valid) begin
            r_mode   <= i_mode;
            r_code   <= i_event_code;
            r_haddr  <= i_host_addr;
            r_hwdata <= i_host_wdata;
        end
        if (r_state == S_OUT && out_free) begin
            r_o_sda     <= r_sda;
            r_o_busy    <= r_busy;
            r_o_free    <= r_p_free;
            r_o_write   <= r_p_write;
            r_o_read    <= r_p_read;
            r_o_matched <= r_matched;
            r_o_hread   <= r_hread;
        end
    end

    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr_count <= 3'd0;
            r_mem_size   <= 9'd256;
            for (int i = 0; i < ADDR_SLOTS; i++) begin
                r_slave_addr[i] <= SLAVE_ADDR_RST;
            end
        end else if (cfg_we) begin
            if (cfg_idx == REG_ADDR_COUNT) begin
                r_addr_count <= pwdata[2:0];
            end
            if (cfg_idx == REG_MEM_SIZE) begin
                r_mem_size <= pwdata[8:0];
            end
            for (int i = 0; i < ADDR_SLOTS; i++) begin
                if (i < NUM_ADDR_REGS && cfg_idx == REG_SLAVE_ADDR0 + 3'(i)) begin
                    r_slave_addr[i] <= pwdata[6:0];
                end
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (cfg_idx == REG_ADDR_COUNT) begin
            prdata = PDATA_W'(r_addr_count);
        end else if (cfg_idx == REG_MEM_SIZE) begin
            prdata = PDATA_W'(r_mem_size);
        end
        for (int i = 0; i < ADDR_SLOTS; i++) begin
            if (i < NUM_ADDR_REGS && cfg_idx == REG_SLAVE_ADDR0 + 3'(i)) begin
                prdata = PDATA_W'(r_slave_addr[i]);
            end
        end
    end

    assign pready             = 1'b1;
    assign o_out_valid        = r_o_valid;
    assign o_sda_drive_low    = r_o_sda;
    assign o_bus_busy         = r_o_busy;
    assign o_bus_free_pulse   = r_o_free;
    assign o_write_done_pulse = r_o_write;
    assign o_read_done_pulse  = r_o_read;
    assign o_matched_address  = r_o_matched;
    assign o_host_read_data   = r_o_hread;

endmodule

/* rtl/core/i2cee_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module i2cee_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
